@@ rtl/earliest_free_worker_scheduler_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the earliest-free worker scheduler
// Concurrent assertion wrappers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef EARLIEST_FREE_WORKER_SCHEDULER_CORE_ASSERT_SVH
`define EARLIEST_FREE_WORKER_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk while the active-low reset is released.
`define EFWS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("efws assertion failed");
// Checked on every rising edge of clk, reset included.
`define EFWS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("efws assertion failed");
`else
`define EFWS_ASSERT(lbl, clk, rstn, prop)
`define EFWS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/efws_pkg.sv @@
// ----------------------------------------------------------------------------
// Earliest-free worker scheduler package
// Controller state type and the fixed field widths of the block's ports.
// ----------------------------------------------------------------------------
package efws_pkg;

    // Fixed widths of the configuration register and stream fields.
    localparam int CFG_W      = 9;
    localparam int DUR_W      = 32;
    localparam int OUT_ID_W   = 8;
    localparam int OUT_TIME_W = 48;
    localparam int OUT_W      = OUT_ID_W + OUT_TIME_W;

    // Controller states: reset sweep, waiting for a job, child read, compare.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CMP
    } t_state;

endpackage

@@ rtl/efws_heap_ram.sv @@
// ----------------------------------------------------------------------------
// Heap storage
// Single-write, dual-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module efws_heap_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 56
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr_a,
    input  logic [AW-1:0] i_rd_addr_b,
    output logic [DW-1:0] o_rd_data_a,
    output logic [DW-1:0] o_rd_data_b
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Both read ports always return registered data for the address given the cycle before.
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

@@ rtl/earliest_free_worker_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// Earliest-free worker scheduler core
// Min-heap list scheduler: each job goes to the worker that frees up first.
// ----------------------------------------------------------------------------
// Every job request on the slave stream is given to the worker whose free
// time is lowest, with the lower worker id winning a tie, and the master
// stream returns that worker id together with its free time as the start
// time. The block then advances that worker's free time by the job duration,
// saturating at all ones, and restores the heap with a sift-down from the
// root. The heap lives in a RAM with two read ports and one write port; each
// heap level is handled in a read state that fetches both children and a
// compare state that writes back, and no new job is taken until the sift
// ends; the entry moves down at most floor(log2(N)) levels for N workers in
// use. After reset the block runs a clearing pass over all MAX_WORKERS slots
// that loads worker i at time zero into slot i; no job is taken during that
// pass, while configuration writes are taken at any time. The worker count
// should only be written while no job is in flight, and changing it does not
// rebuild the heap.
// ----------------------------------------------------------------------------
`include "earliest_free_worker_scheduler_core_assert.svh"

module earliest_free_worker_scheduler_core #(
    parameter int MAX_WORKERS = 256,
    parameter int TIME_BITS   = 48
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration: worker_count.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [efws_pkg::CFG_W-1:0]   i_cfg_data,
    // Job requests; tdata holds job_duration.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [efws_pkg::DUR_W-1:0]   s_tdata,
    // Assignments; tdata holds worker_id [7:0], start_time [55:8].
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [efws_pkg::OUT_W-1:0]   m_tdata
);

    import efws_pkg::*;

    localparam int ID_BITS = $clog2(MAX_WORKERS);
    localparam int EW      = TIME_BITS + ID_BITS;
    // Wide enough for the worker count, the heap size and any child index.
    localparam int CMP_W   = ((ID_BITS + 2) > CFG_W ? (ID_BITS + 2) : CFG_W) + 1;
    localparam logic [ID_BITS-1:0] LAST_ADDR = ID_BITS'(MAX_WORKERS - 1);

    // A heap entry packs the free time above the worker id, so a plain
    // unsigned compare of two entries orders by time first and id second.
    t_state               r_state;
    t_state               n_state;
    logic [ID_BITS-1:0]   r_clr_addr;
    logic [CFG_W-1:0]     r_wcount;
    logic [CMP_W-1:0]     r_size;
    logic [ID_BITS-1:0]   r_pos;
    logic [EW-1:0]        r_cur;
    logic [EW-1:0]        r_root;
    logic                 r_m_valid;
    logic [OUT_W-1:0]     r_m_data;

    logic                 w_accept;
    logic                 w_wr_en;
    logic [ID_BITS-1:0]   w_wr_addr;
    logic [EW-1:0]        w_wr_data;
    logic [EW-1:0]        w_rd_l;
    logic [EW-1:0]        w_rd_r;

    // Heap size: a count of zero means one worker, and it is clamped to the
    // storage depth.
    logic [CMP_W-1:0]     w_wc_ext;
    logic [CMP_W-1:0]     w_size;
    always_comb begin
        w_wc_ext = CMP_W'(r_wcount);
        if (w_wc_ext == '0) begin
            w_size = CMP_W'(1);
        end else if (w_wc_ext > CMP_W'(MAX_WORKERS)) begin
            w_size = CMP_W'(MAX_WORKERS);
        end else begin
            w_size = w_wc_ext;
        end
    end

    // Children of the current slot, zero based: 2p+1 and 2p+2.
    logic [CMP_W-1:0]     w_left_ix;
    logic [CMP_W-1:0]     w_right_ix;
    logic [ID_BITS-1:0]   w_left_addr;
    logic [ID_BITS-1:0]   w_right_addr;
    assign w_left_ix    = (CMP_W'(r_pos) << 1) + CMP_W'(1);
    assign w_right_ix   = w_left_ix + CMP_W'(1);
    assign w_left_addr  = w_left_ix[ID_BITS-1:0];
    assign w_right_addr = w_right_ix[ID_BITS-1:0];

    // Pick the smallest of the moving entry and its children in parallel.
    logic w_l_ok;
    logic w_r_ok;
    logic w_l_lt_cur;
    logic w_r_lt_cur;
    logic w_r_lt_l;
    logic w_pick_l;
    logic w_pick_r;
    assign w_l_ok     = w_left_ix < r_size;
    assign w_r_ok     = w_right_ix < r_size;
    assign w_l_lt_cur = w_rd_l < r_cur;
    assign w_r_lt_cur = w_rd_r < r_cur;
    assign w_r_lt_l   = w_rd_r < w_rd_l;
    assign w_pick_r   = w_r_ok && w_r_lt_cur && (!w_l_ok || w_r_lt_l);
    assign w_pick_l   = w_l_ok && w_l_lt_cur && !(w_r_ok && w_r_lt_l);

    // The root's new free time: add the duration and saturate.
    logic [TIME_BITS:0]   w_sum;
    logic [TIME_BITS-1:0] w_new_time;
    assign w_sum      = {1'b0, r_root[EW-1:ID_BITS]} + (TIME_BITS + 1)'(s_tdata);
    assign w_new_time = w_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : w_sum[TIME_BITS-1:0];

    // Result fields carry only the low bits of wide ids and times.
    logic [ID_BITS+OUT_ID_W-1:0]      w_id_ext;
    logic [TIME_BITS+OUT_TIME_W-1:0]  w_time_ext;
    assign w_id_ext   = {{OUT_ID_W{1'b0}}, r_root[ID_BITS-1:0]};
    assign w_time_ext = {{OUT_TIME_W{1'b0}}, r_root[EW-1:ID_BITS]};

    assign w_accept = s_tvalid && s_tready;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_pick_l || w_pick_r) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Output logic: request ready and the RAM write port.
    always_comb begin
        s_tready  = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = r_cur;
        case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_addr;
                w_wr_data = {{TIME_BITS{1'b0}}, r_clr_addr};
            end
            S_IDLE: begin
                s_tready = !r_m_valid || m_tready;
            end
            S_READ: begin
                w_wr_en = 1'b0;
            end
            S_CMP: begin
                w_wr_en = 1'b1;
                if (w_pick_r) begin
                    w_wr_data = w_rd_r;
                end else if (w_pick_l) begin
                    w_wr_data = w_rd_l;
                end
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_wcount   <= CFG_W'(1);
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ID_BITS'(1);
            end
            if (i_cfg_valid) begin
                r_wcount <= i_cfg_data;
            end
            if (w_accept) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= {w_time_ext[OUT_TIME_W-1:0], w_id_ext[OUT_ID_W-1:0]};
            r_cur    <= {w_new_time, r_root[ID_BITS-1:0]};
            r_pos    <= '0;
            r_size   <= w_size;
        end else if (r_state == S_CMP) begin
            if (w_pick_r) begin
                r_pos <= w_right_addr;
            end else if (w_pick_l) begin
                r_pos <= w_left_addr;
            end
        end
        // The root is mirrored in a register so a job can be answered at once.
        if (w_wr_en && (w_wr_addr == '0)) begin
            r_root <= w_wr_data;
        end
    end

    efws_heap_ram #(
        .DEPTH (MAX_WORKERS),
        .AW    (ID_BITS),
        .DW    (EW)
    ) u_heap_ram (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_addr_a (w_left_addr),
        .i_rd_addr_b (w_right_addr),
        .o_rd_data_a (w_rd_l),
        .o_rd_data_b (w_rd_r)
    );

    assign o_cfg_ready = 1'b1;
    assign m_tvalid    = r_m_valid;
    assign m_tdata     = r_m_data;

    // An accepted request always leaves a result waiting on the next cycle.
    `EFWS_ASSERT(a_accept_gives_result, i_clk, i_rst_n, w_accept |=> m_tvalid)
    // Sift writes never land outside the heap in use.
    `EFWS_ASSERT(a_write_in_heap, i_clk, i_rst_n,
        (r_state == S_CMP) |-> (CMP_W'(r_pos) < r_size))
    // Each level moved goes strictly deeper in the heap.
    `EFWS_ASSERT(a_sift_descends, i_clk, i_rst_n,
        (r_state == S_CMP && n_state == S_READ) |=> (r_pos > $past(r_pos)))
    // The clearing pass hands over to idle once the last slot is written.
    `EFWS_ASSERT(a_clear_ends, i_clk, i_rst_n,
        (r_state == S_CLEAR && r_clr_addr == LAST_ADDR) |=> (r_state == S_IDLE))

endmodule
